// ===== rtl/ffra_pkg.sv =====
// Shared types, sizes and codes for the first-fit range allocator.
package ffra_pkg;

    // Table size and field widths
    localparam int MAX_RANGES = 64;
    localparam int START_W    = 20;
    localparam int LEN_W      = 21;
    localparam logic [LEN_W-1:0] LIMIT_UNITS = LEN_W'(1) << START_W;

    typedef logic [START_W-1:0] t_start;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [2:0]         t_op;

    // Cell commands
    localparam t_op OP_NOP   = 3'd0;
    localparam t_op OP_LOAD  = 3'd1;
    localparam t_op OP_EVAL  = 3'd2;
    localparam t_op OP_ALLOC = 3'd3;
    localparam t_op OP_FREE  = 3'd4;
    localparam t_op OP_MERGE = 3'd5;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Command broadcast to every cell
    typedef struct packed {
        t_op    op;
        t_start s;     // start of freed range
        t_len   len;   // request or free length
        t_len   e;     // clipped end of freed range
        t_len   cap;   // capacity for a reload
    } t_cmd;

    // What a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        t_start s;
        t_len   len;
        t_len   fin;   // s + len
        logic   below; // range ends before the freed start
    } t_entry;

    // Prefix flags rippling from cell 0 upward
    typedef struct packed {
        logic fit;  // a fitting range seen to the left
        logic rm;   // an entry removed to the left
        logic ins;  // an entry inserted to the left
        logic mrg;  // a neighbor merge to the left
    } t_link;

endpackage

// ===== rtl/ffra_cell.sv =====
// One free-list entry cell: holds a range and shifts with its neighbors.
module ffra_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head,
    input  ffra_pkg::t_cmd   i_cmd,
    input  ffra_pkg::t_entry i_prev,
    input  ffra_pkg::t_entry i_next,
    input  ffra_pkg::t_link  i_link,
    output ffra_pkg::t_link  o_link,
    output ffra_pkg::t_entry o_entry,
    output logic            o_inm,
    output ffra_pkg::t_start o_grant
);
    import ffra_pkg::*;

    logic   r_valid, n_valid;
    t_start r_s, n_s;
    t_len   r_len, n_len;
    logic   r_fit, n_fit;
    logic   r_exact, n_exact;
    logic   r_below, n_below;
    logic   r_inm, n_inm;

    t_len   w_fin;
    t_len   w_lo_start;
    t_len   w_hi_end;
    t_len   w_mrg_end;
    logic   w_first;
    logic   w_is_lo;
    logic   w_m;

    // Local terms
    assign w_fin      = LEN_W'(r_s) + r_len;
    assign w_first    = r_fit && !i_link.fit;
    assign w_is_lo    = !r_below && (i_head || i_prev.below);
    assign w_m        = r_valid && i_next.valid && (LEN_W'(i_next.s) <= w_fin);
    assign w_lo_start = (LEN_W'(i_cmd.s) < LEN_W'(r_s)) ? LEN_W'(i_cmd.s) : LEN_W'(r_s);
    assign w_hi_end   = (i_cmd.e > w_fin) ? i_cmd.e : w_fin;
    assign w_mrg_end  = (i_next.fin > w_fin) ? i_next.fin : w_fin;

    // Prefix flags to the right-hand neighbor
    assign o_link.fit = i_link.fit | r_fit;
    assign o_link.rm  = i_link.rm  | (w_first && r_exact);
    assign o_link.ins = i_link.ins | (w_is_lo && !r_inm);
    assign o_link.mrg = i_link.mrg | w_m;

    assign o_entry.valid = r_valid;
    assign o_entry.s     = r_s;
    assign o_entry.len   = r_len;
    assign o_entry.fin   = w_fin;
    assign o_entry.below = r_below;
    assign o_inm         = r_inm;
    assign o_grant       = w_first ? r_s : '0;

    // Next entry per command
    always_comb begin
        n_valid = r_valid;
        n_s     = r_s;
        n_len   = r_len;
        n_fit   = r_fit;
        n_exact = r_exact;
        n_below = r_below;
        n_inm   = r_inm;
        unique case (i_cmd.op)
            OP_LOAD: begin
                n_valid = i_head && (i_cmd.cap != '0);
                n_s     = '0;
                n_len   = i_head ? i_cmd.cap : '0;
            end
            OP_EVAL: begin
                n_fit   = r_valid && (r_len >= i_cmd.len);
                n_exact = (r_len == i_cmd.len);
                n_below = r_valid && (w_fin < LEN_W'(i_cmd.s));
                n_inm   = r_valid && (w_fin >= LEN_W'(i_cmd.s))
                          && (LEN_W'(r_s) <= i_cmd.e);
            end
            OP_ALLOC: begin
                if (w_first && !r_exact) begin
                    n_s   = START_W'(LEN_W'(r_s) + i_cmd.len);
                    n_len = r_len - i_cmd.len;
                end else if (w_first || i_link.rm) begin
                    n_valid = i_next.valid;
                    n_s     = i_next.s;
                    n_len   = i_next.len;
                end
            end
            OP_FREE: begin
                if (r_below) begin
                    n_valid = r_valid;
                end else if (w_is_lo && r_inm) begin
                    n_s   = START_W'(w_lo_start);
                    n_len = w_hi_end - w_lo_start;
                end else if (w_is_lo) begin
                    n_valid = 1'b1;
                    n_s     = i_cmd.s;
                    n_len   = i_cmd.e - LEN_W'(i_cmd.s);
                end else if (i_link.ins) begin
                    n_valid = i_prev.valid;
                    n_s     = i_prev.s;
                    n_len   = i_prev.len;
                end
            end
            OP_MERGE: begin
                if (w_m) begin
                    n_len = w_mrg_end - LEN_W'(r_s);
                end else if (i_link.mrg) begin
                    n_valid = i_next.valid;
                    n_s     = i_next.s;
                    n_len   = i_next.len;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    // Cell registers; reset leaves one full-size range in the head cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= i_head;
            r_s     <= '0;
            r_len   <= i_head ? LIMIT_UNITS : '0;
            r_fit   <= 1'b0;
            r_exact <= 1'b0;
            r_below <= 1'b0;
            r_inm   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_s     <= n_s;
            r_len   <= n_len;
            r_fit   <= n_fit;
            r_exact <= n_exact;
            r_below <= n_below;
            r_inm   <= n_inm;
        end
    end

endmodule

// ===== rtl/first_fit_range_allocator.sv =====
// Sequence: an accepted request passes the EVAL (evaluate), APPLY and DONE (deliver) states in turn.
// A free that touches stored ranges also passes MERGE, which repeats while a neighbor merge remains.
// One item in flight: no new input is taken until DONE has loaded the result into the output register.
// Reset (synchronous, active low): capacity 2^20, list holds one range from 0; no clear sweep.
// A capacity write reloads the list in the same cycle.
module first_fit_range_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [19:0] start_req, [40:20] length, rest zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [19:0] granted_start, [40:20] granted_length
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffra_pkg::*;

    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    t_len       r_cap;
    logic       r_kind;
    t_start     r_s;
    t_len       r_len;
    t_len       r_e;
    logic       r_zero;
    logic       r_skip;
    logic [1:0] r_status;
    t_start     r_gs;
    t_len       r_gl;
    logic       r_ov;
    logic [1:0] r_out_status;
    t_start     r_out_gs;
    t_len       r_out_gl;

    t_cmd       w_cmd;
    t_entry     w_entry [MAX_RANGES];
    t_link      w_link  [MAX_RANGES+1];
    logic       w_inm   [MAX_RANGES];
    t_start     w_grant [MAX_RANGES];
    logic       w_any_m;
    t_start     w_grant_or;
    logic       w_full;
    logic       w_any_fit;
    logic       w_any_mrg;
    logic       w_cfg_wr;
    t_len       w_cap_sat;
    t_start     w_in_s;
    t_len       w_in_len;
    logic [LEN_W:0] w_sum;
    logic       w_accept;
    logic       w_load_out;

    // Configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign w_cap_sat = (pwdata[START_W] && (pwdata[START_W-1:0] != '0))
                       ? LIMIT_UNITS : pwdata[LEN_W-1:0];
    assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(r_cap) : '0;

    // Input side
    assign s_tready = (r_state == S_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_in_s   = s_tdata[START_W-1:0];
    assign w_in_len = s_tdata[START_W+LEN_W-1:START_W];
    assign w_sum    = (LEN_W+1)'(w_in_s) + (LEN_W+1)'(w_in_len);

    // Cell row
    assign w_link[0] = '0;
    for (genvar j = 0; j < MAX_RANGES; j++) begin : g_cell
        ffra_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_head  (j == 0),
            .i_cmd   (w_cmd),
            .i_prev  ((j == 0) ? t_entry'('0) : w_entry[(j == 0) ? 0 : j-1]),
            .i_next  ((j == MAX_RANGES-1) ? t_entry'('0)
                                          : w_entry[(j == MAX_RANGES-1) ? j : j+1]),
            .i_link  (w_link[j]),
            .o_link  (w_link[j+1]),
            .o_entry (w_entry[j]),
            .o_inm   (w_inm[j]),
            .o_grant (w_grant[j])
        );
    end

    // Row-wide summaries
    always_comb begin
        w_any_m    = 1'b0;
        w_grant_or = '0;
        for (int k = 0; k < MAX_RANGES; k++) begin
            w_any_m    = w_any_m | w_inm[k];
            w_grant_or = w_grant_or | w_grant[k];
        end
    end
    assign w_full    = w_entry[MAX_RANGES-1].valid;
    assign w_any_fit = w_link[MAX_RANGES].fit;
    assign w_any_mrg = w_link[MAX_RANGES].mrg;

    // Command to the row
    always_comb begin
        w_cmd.s   = r_s;
        w_cmd.len = r_len;
        w_cmd.e   = r_e;
        w_cmd.cap = w_cap_sat;
        w_cmd.op  = OP_NOP;
        if (w_cfg_wr) begin
            w_cmd.op = OP_LOAD;
        end else begin
            unique case (r_state)
                S_EVAL:  w_cmd.op = OP_EVAL;
                S_APPLY: begin
                    if (r_kind) begin
                        w_cmd.op = (r_skip || (!w_any_m && w_full)) ? OP_NOP : OP_FREE;
                    end else begin
                        w_cmd.op = r_zero ? OP_NOP : OP_ALLOC;
                    end
                end
                S_MERGE: w_cmd.op = OP_MERGE;
                default: w_cmd.op = OP_NOP;
            endcase
        end
    end

    assign w_load_out = (r_state == S_DONE) && (!r_ov || m_tready);

    // Sequencer and request/result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= LIMIT_UNITS;
            r_ov    <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_cap <= w_cap_sat;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL:  r_state <= S_APPLY;
                S_APPLY: begin
                    r_state <= (r_kind && !r_skip && w_any_m) ? S_MERGE : S_DONE;
                end
                S_MERGE: begin
                    if (!w_any_mrg) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= s_tuser;
            r_s    <= w_in_s;
            r_len  <= w_in_len;
            r_e    <= (w_sum > (LEN_W+1)'(r_cap)) ? r_cap : w_sum[LEN_W-1:0];
            r_zero <= (w_in_len == '0);
            r_skip <= (w_in_len == '0) || (LEN_W'(w_in_s) >= r_cap);
        end
        if (r_state == S_APPLY) begin
            if (r_kind) begin
                r_status <= (!r_skip && !w_any_m && w_full) ? STAT_FULL : STAT_OK;
                r_gs     <= '0;
                r_gl     <= '0;
            end else begin
                r_status <= (r_zero || w_any_fit) ? STAT_OK : STAT_NOFIT;
                r_gs     <= (!r_zero && w_any_fit) ? w_grant_or : '0;
                r_gl     <= (!r_zero && w_any_fit) ? r_len : '0;
            end
        end
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_gs     <= r_gs;
            r_out_gl     <= r_gl;
        end
    end

    // Output side
    assign m_tvalid = r_ov;
    assign m_tuser  = r_out_status;
    assign m_tdata  = {7'b0, r_out_gl, r_out_gs};

endmodule

// ===== dv/first_fit_range_allocator_tb.sv =====
// Self-checking testbench for the first-fit range allocator: stream stimulus, APB setup, scoreboard.
module first_fit_range_allocator_tb;
    import ffra_pkg::*;

    localparam logic       KIND_ALLOC   = 1'b0;
    localparam logic       KIND_FREE    = 1'b1;
    localparam logic [2:0] REG_CAPACITY = 3'd0;
    localparam logic [2:0] REG_SPARE    = 3'd4;  // no register decoded here
    localparam int unsigned UNIT_LIMIT  = 32'd1 << START_W;
    localparam int unsigned START_MASK  = UNIT_LIMIT - 1;

    typedef struct {
        logic   kind;
        t_start start_req;
        t_len   length;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        t_start     gstart;
        t_len       glen;
    } t_grant;

    typedef struct {
        int unsigned s;
        int unsigned n;
    } t_span;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [19:0] start_req, [40:20] length, rest zero
    logic        s_tuser  = 1'b0; // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [19:0] granted_start, [40:20] granted_length
    logic [1:0]  m_tuser;         // [1:0] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    first_fit_range_allocator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial forever #10 i_clk = ~i_clk;

    // Shadow free list
    int unsigned cap_units;
    int unsigned fl_start [MAX_RANGES];
    int unsigned fl_len   [MAX_RANGES];
    int          fl_count;

    t_req   request_q [$];
    t_grant grant_q   [$];
    t_span  held_q    [$];   // ranges granted and not yet handed back
    t_req   cur_req;
    int     send_gap  = 0;
    int     stall_left = 0;
    int     err_count = 0;
    bit     calm      = 1'b0;

    function automatic void load_units(int unsigned value);
        cap_units = (value > UNIT_LIMIT) ? UNIT_LIMIT : value;
        for (int i = 0; i < MAX_RANGES; i++) begin
            fl_start[i] = 0;
            fl_len[i]   = 0;
        end
        fl_count  = (cap_units == 0) ? 0 : 1;
        fl_len[0] = cap_units;
    endfunction

    function automatic void drop_slot(int idx);
        for (int i = idx; i + 1 < fl_count; i++) begin
            fl_start[i] = fl_start[i + 1];
            fl_len[i]   = fl_len[i + 1];
        end
        fl_count--;
        fl_start[fl_count] = 0;
        fl_len[fl_count]   = 0;
    endfunction

    // First fit: carve the grant from the front of the first range long enough
    function automatic t_grant grab_range(int unsigned len);
        t_grant g;
        t_span  sp;
        g = '0;
        if (len == 0)
            return g;
        for (int i = 0; i < fl_count; i++) begin
            if (fl_len[i] >= len) begin
                g.gstart    = t_start'(fl_start[i]);
                g.glen      = t_len'(len);
                sp.s        = fl_start[i];
                sp.n        = len;
                held_q.insert(held_q.size(), sp);
                fl_start[i] = (fl_start[i] + len) & START_MASK;
                fl_len[i]   = fl_len[i] - len;
                if (fl_len[i] == 0)
                    drop_slot(i);
                return g;
            end
        end
        g.status = STAT_NOFIT;
        return g;
    endfunction

    // Put a range back, clipped to capacity, merged with all it touches
    function automatic logic [1:0] release_range(int unsigned s, int unsigned len);
        int unsigned e, ns, ne, last_end;
        int          lo, hi;
        if (len == 0 || s >= cap_units)
            return STAT_OK;
        e = s + len;
        if (e > cap_units)
            e = cap_units;
        lo = 0;
        while (lo < fl_count && fl_start[lo] + fl_len[lo] < s)
            lo++;
        hi = lo;
        while (hi < fl_count && fl_start[hi] <= e)
            hi++;
        if (lo == hi) begin
            if (fl_count >= MAX_RANGES)
                return STAT_FULL;
            for (int i = fl_count; i > lo; i--) begin
                fl_start[i] = fl_start[i - 1];
                fl_len[i]   = fl_len[i - 1];
            end
            fl_start[lo] = s;
            fl_len[lo]   = e - s;
            fl_count++;
            return STAT_OK;
        end
        ns       = (fl_start[lo] < s) ? fl_start[lo] : s;
        last_end = fl_start[hi - 1] + fl_len[hi - 1];
        ne       = (last_end > e) ? last_end : e;
        fl_start[lo] = ns;
        fl_len[lo]   = ne - ns;
        for (int k = hi - lo - 1; k > 0; k--)
            drop_slot(lo + 1);
        return STAT_OK;
    endfunction

    function automatic void track_request(t_req r);
        t_grant g;
        g = '0;
        if (r.kind == KIND_ALLOC)
            g = grab_range(r.length);
        else
            g.status = release_range(r.start_req, r.length);
        grant_q.insert(grant_q.size(), g);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        err_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // Driver: one transfer per handshake, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                track_request(cur_req);
            if (!s_tvalid || s_tready) begin
                if (send_gap == 0 && !calm && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 14);
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.kind;
                    s_tdata  <= {7'd0, cur_req.length, cur_req.start_req};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each result with the oldest grant
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (grant_q.size() == 0) begin
                    report_mismatch("unexpected result, status", m_tuser, 0);
                end else begin
                    want = grant_q.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[19:0] != want.gstart)
                        report_mismatch("granted_start", m_tdata[19:0], want.gstart);
                    if (m_tdata[40:20] != want.glen)
                        report_mismatch("granted_length", m_tdata[40:20], want.glen);
                end
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_req(logic kind, int unsigned s, int unsigned len);
        t_req r;
        r.kind      = kind;
        r.start_req = t_start'(s);
        r.length    = t_len'(len);
        while (request_q.size() > 2)
            @(negedge i_clk);
        request_q.insert(request_q.size(), r);
    endtask

    // Wait until every item is sent and every result is back
    task automatic settle();
        @(negedge i_clk);
        while (request_q.size() != 0 || s_tvalid || grant_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_CAPACITY) begin
            load_units(data[LEN_W-1:0]);
            held_q.delete();
        end
    endtask

    function automatic int unsigned pick_len(int unsigned cap);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 6)
            return UNIT_LIMIT;
        if (r < 10)
            return $urandom_range(1, cap);
        if (r < 15)
            return (cap + cap / 2 + 1 > UNIT_LIMIT) ? UNIT_LIMIT
                                                    : $urandom_range(cap, cap + cap / 2 + 1);
        return $urandom_range(1, cap / 16 + 1);
    endfunction

    // Mostly allocate/hand-back pairs on live grants, some stray frees
    task automatic run_mix(int count, int pause_at);
        int unsigned r, idx, cut, s, len;
        t_span       sp;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                settle();
            r = $urandom_range(0, 99);
            if (r < 40 && held_q.size() > 0) begin
                idx = $urandom_range(0, held_q.size() - 1);
                sp  = held_q[idx];
                held_q.delete(idx);
                r = $urandom_range(0, 9);
                if (r < 6 || sp.n < 2) begin
                    push_req(KIND_FREE, sp.s, sp.n);
                end else begin
                    cut = $urandom_range(1, sp.n - 1);
                    if (r < 8) begin
                        push_req(KIND_FREE, sp.s, cut);
                        sp.s = sp.s + cut;
                        sp.n = sp.n - cut;
                        held_q.insert(held_q.size(), sp);
                    end else begin
                        push_req(KIND_FREE, sp.s + cut, sp.n - cut);
                        sp.n = cut;
                        held_q.insert(held_q.size(), sp);
                    end
                end
            end else if (r < 85) begin
                push_req(KIND_ALLOC, $urandom_range(0, START_MASK), pick_len(cap_units));
            end else begin
                s   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, START_MASK)
                                                  : ($urandom_range(0, cap_units + 8)
                                                     & START_MASK);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, UNIT_LIMIT)
                                                  : $urandom_range(0, cap_units / 8 + 2);
                push_req(KIND_FREE, s, len);
            end
        end
        settle();
    endtask

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        load_units(UNIT_LIMIT);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset capacity: zero-length alloc, exact fit empties the list, double free
        push_req(KIND_ALLOC, 0, 0);
        push_req(KIND_ALLOC, START_MASK, 1);
        push_req(KIND_ALLOC, 0, UNIT_LIMIT);
        push_req(KIND_ALLOC, 0, UNIT_LIMIT - 1);
        push_req(KIND_ALLOC, 0, 1);
        push_req(KIND_FREE, 0, 1);
        push_req(KIND_FREE, START_MASK, 1);
        push_req(KIND_FREE, 5, 0);
        push_req(KIND_FREE, 0, UNIT_LIMIT);
        push_req(KIND_ALLOC, 0, 16);
        push_req(KIND_FREE, 8, 4);
        push_req(KIND_FREE, 12, 4);
        push_req(KIND_FREE, 0, 8);
        push_req(KIND_ALLOC, 0, UNIT_LIMIT);
        push_req(KIND_FREE, START_MASK, 2);          // end clipped to capacity
        push_req(KIND_FREE, 0, UNIT_LIMIT - 1);
        settle();

        // Zero capacity, then a write to an undecoded address
        apb_write(REG_CAPACITY, 32'd0);
        push_req(KIND_ALLOC, 0, 1);
        push_req(KIND_ALLOC, 0, 0);
        push_req(KIND_FREE, 0, 5);
        settle();
        apb_write(REG_SPARE, 32'd7);
        push_req(KIND_ALLOC, 0, 1);
        settle();

        // Capacity above range saturates
        apb_write(REG_CAPACITY, 32'h001F_FFFF);
        push_req(KIND_ALLOC, 0, UNIT_LIMIT);
        push_req(KIND_FREE, 100, 50);
        settle();

        // Capacity of one unit; free past the end is ignored
        apb_write(REG_CAPACITY, 32'd1);
        push_req(KIND_ALLOC, 0, 2);
        push_req(KIND_ALLOC, 0, 1);
        push_req(KIND_FREE, 1, 1);
        push_req(KIND_FREE, 0, 1);
        settle();

        // Fill the table with isolated one-unit holes, then overflow it
        apb_write(REG_CAPACITY, 32'd200);
        push_req(KIND_ALLOC, 0, 200);
        for (int k = 0; k < MAX_RANGES; k++)
            push_req(KIND_FREE, 2 * k, 1);
        push_req(KIND_FREE, 130, 1);
        push_req(KIND_FREE, 127, 1);
        push_req(KIND_FREE, 150, 60);
        push_req(KIND_FREE, 0, 200);
        settle();

        // Random phases over several capacities
        apb_write(REG_CAPACITY, UNIT_LIMIT);
        run_mix(210, -1);
        apb_write(REG_CAPACITY, 32'd1000);
        run_mix(210, 100);
        apb_write(REG_CAPACITY, 32'hFFE0_0040);     // upper bits ignored
        run_mix(210, -1);
        apb_write(REG_CAPACITY, 32'd300);
        run_mix(210, 120);
        apb_write(REG_CAPACITY, $urandom_range(1, UNIT_LIMIT));
        run_mix(210, -1);
        calm = 1'b1;
        apb_write(REG_CAPACITY, 32'd5000);
        run_mix(210, -1);

        repeat (80) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
